// ===== rtl/brlg_pkg.sv =====
// Shared constants and types for the Bresenham line generator.
`default_nettype none
package brlg_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ===== rtl/brlg_front.sv =====
// Front end: accepts items and precomputes the line setup for start items.
`default_nettype none
module brlg_front #(
  parameter int COORD_BITS = 12,
  localparam int ENTRY_W = 6 * COORD_BITS + 4
) (
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  input  wire logic [4*COORD_BITS-1:0] in_fields,
  input  wire logic                    in_kind,
  input  wire brlg_pkg::q_stat_t       q_stat,
  output logic                         q_push,
  output logic [ENTRY_W-1:0]           q_entry
);
  import brlg_pkg::*;

  localparam int C = COORD_BITS;

  logic signed [C-1:0] x0, y0, x1, y1;
  logic signed [C:0]   ddx, ddy;
  logic        [C:0]   abs_dx;
  logic        [C-1:0] span_x;
  logic signed [C:0]   neg_span_y;
  logic                step_x_neg, step_y_neg;

  always_comb begin
    x0 = $signed(in_fields[C-1:0]);
    y0 = $signed(in_fields[2*C-1:C]);
    x1 = $signed(in_fields[3*C-1:2*C]);
    y1 = $signed(in_fields[4*C-1:3*C]);
    ddx = $signed({x1[C-1], x1}) - $signed({x0[C-1], x0});
    ddy = $signed({y1[C-1], y1}) - $signed({y0[C-1], y0});
    abs_dx = ddx[C] ? (-ddx) : ddx;
    span_x = abs_dx[C-1:0];
    neg_span_y = ddy[C] ? ddy : (-ddy);
    step_x_neg = !(x0 < x1);
    step_y_neg = !(y0 < y1);
  end

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && !q_stat.full;
  assign q_entry   = {step_y_neg, step_x_neg, neg_span_y, span_x,
                      in_fields, in_kind};

endmodule
`default_nettype wire

// ===== rtl/brlg_queue.sv =====
// Short register queue between the front end and the stepper.
`default_nettype none
module brlg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] head_data,
  output brlg_pkg::q_stat_t     stat
);
  import brlg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/brlg_stepper.sv =====
// Back end: holds the line state, loads it on a start item, steps it per tick and registers the point.
`default_nettype none
module brlg_stepper #(
  parameter int COORD_BITS = 12,
  localparam int ENTRY_W = 6 * COORD_BITS + 4
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire brlg_pkg::q_stat_t  q_stat,
  input  wire logic [ENTRY_W-1:0] q_entry,
  output logic                    q_pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [COORD_BITS-1:0]   out_px,
  output logic [COORD_BITS-1:0]   out_py,
  output logic                    out_tlast
);
  import brlg_pkg::*;

  localparam int C = COORD_BITS;

  logic                kind;
  logic [C-1:0]        e_x0, e_y0, e_x1, e_y1, e_span_x;
  logic signed [C:0]   e_neg_span_y;
  logic                e_sxn, e_syn;

  logic [C-1:0]        cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [C-1:0]        goal_x_r, goal_x_nxt, goal_y_r, goal_y_nxt;
  logic [C-1:0]        span_x_r, span_x_nxt;
  logic signed [C:0]   neg_span_y_r, neg_span_y_nxt;
  logic                sxn_r, sxn_nxt, syn_r, syn_nxt;
  logic signed [C+1:0] err_r, err_nxt, err_mid;
  logic                active_r, active_nxt;

  logic                out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [C-1:0]        out_px_r, out_px_nxt, out_py_r, out_py_nxt;

  logic signed [C+2:0] e2, nsy_ext, sx_ext;
  logic                emit, fin;

  assign {e_syn, e_sxn, e_neg_span_y, e_span_x, e_y1, e_x1, e_y0, e_x0, kind} = q_entry;

  assign q_pop = !q_stat.empty && (!out_valid_r || out_tready);

  always_comb begin
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    goal_x_nxt     = goal_x_r;
    goal_y_nxt     = goal_y_r;
    span_x_nxt     = span_x_r;
    neg_span_y_nxt = neg_span_y_r;
    sxn_nxt        = sxn_r;
    syn_nxt        = syn_r;
    err_nxt        = err_r;
    err_mid        = err_r;
    active_nxt     = active_r;
    emit           = 1'b0;
    e2      = $signed({err_r, 1'b0});
    nsy_ext = $signed({{2{neg_span_y_r[C]}}, neg_span_y_r});
    sx_ext  = $signed({3'b000, span_x_r});
    if (q_pop) begin
      if (kind == KIND_START) begin
        cur_x_nxt      = e_x0;
        cur_y_nxt      = e_y0;
        goal_x_nxt     = e_x1;
        goal_y_nxt     = e_y1;
        span_x_nxt     = e_span_x;
        neg_span_y_nxt = e_neg_span_y;
        sxn_nxt        = e_sxn;
        syn_nxt        = e_syn;
        err_nxt        = $signed({2'b00, e_span_x}) + $signed({e_neg_span_y[C], e_neg_span_y});
        emit           = 1'b1;
      end else if (active_r) begin
        if (e2 >= nsy_ext) begin
          err_mid   = err_r + $signed({neg_span_y_r[C], neg_span_y_r});
          cur_x_nxt = sxn_r ? (cur_x_r - C'(1)) : (cur_x_r + C'(1));
        end
        err_nxt = err_mid;
        if (e2 <= sx_ext) begin
          err_nxt   = err_mid + $signed({2'b00, span_x_r});
          cur_y_nxt = syn_r ? (cur_y_r - C'(1)) : (cur_y_r + C'(1));
        end
        emit = 1'b1;
      end
    end
    fin = (cur_x_nxt == goal_x_nxt) && (cur_y_nxt == goal_y_nxt);
    if (emit) begin
      active_nxt = !fin;
    end
  end

  always_comb begin
    out_px_nxt   = out_px_r;
    out_py_nxt   = out_py_r;
    out_last_nxt = out_last_r;
    if (q_pop) begin
      out_valid_nxt = emit;
      out_px_nxt    = cur_x_nxt;
      out_py_nxt    = cur_y_nxt;
      out_last_nxt  = fin;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      goal_x_r     <= '0;
      goal_y_r     <= '0;
      span_x_r     <= '0;
      neg_span_y_r <= '0;
      sxn_r        <= 1'b0;
      syn_r        <= 1'b0;
      err_r        <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_x_r      <= cur_x_nxt;
      cur_y_r      <= cur_y_nxt;
      goal_x_r     <= goal_x_nxt;
      goal_y_r     <= goal_y_nxt;
      span_x_r     <= span_x_nxt;
      neg_span_y_r <= neg_span_y_nxt;
      sxn_r        <= sxn_nxt;
      syn_r        <= syn_nxt;
      err_r        <= err_nxt;
      active_r     <= active_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_px_r   <= out_px_nxt;
    out_py_r   <= out_py_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_px     = out_px_r;
  assign out_py     = out_py_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

// ===== rtl/bresenham_line_generator_core.sv =====
// Top level of the Bresenham line generator: front end, queue and stepper.
// An accepted item is written into the queue; when the stepper pops it, the point
// it causes is registered at the output. Throughput: one item per cycle while the
// output is not stalled, set by the error update and step in the stepper; the
// two-entry queue takes up to two items while a point waits. Reset (synchronous,
// active low) empties the queue, clears the line state and drops any pending point.
`default_nettype none
module bresenham_line_generator_core #(
  parameter int COORD_BITS = brlg_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [IN_W-1:0] in_tdata,   // x_start, y_start, x_end, y_end
  input  wire logic            in_tuser,   // kind
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // px, py
  output logic                 out_tlast
);
  import brlg_pkg::*;

  localparam int ENTRY_W = 6 * COORD_BITS + 4;

  q_stat_t                q_stat;
  logic                   q_push, q_pop;
  logic [ENTRY_W-1:0]     push_entry, head_entry;
  logic [COORD_BITS-1:0]  px, py;

  brlg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_fields (in_tdata[4*COORD_BITS-1:0]),
    .in_kind   (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  brlg_queue #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .head_data (head_entry),
    .stat      (q_stat)
  );

  brlg_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_entry    (head_entry),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_px     (px),
    .out_py     (py),
    .out_tlast  (out_tlast)
  );

  assign out_tdata = OUT_W'({py, px});

endmodule
`default_nettype wire

// ===== rtl/brlg_checker.sv =====
// Port-level assertions for the Bresenham line generator, bound to the top level.
`default_nettype none
module brlg_checker #(
  parameter int COORD_BITS = brlg_pkg::COORD_BITS_DEF,
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,  // px, py
  input wire logic             out_tlast
);

  // The output register is empty right after reset.
  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("point presented right after reset");

  // The queue can only be full while a point is waiting at the output.
  a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled without a waiting point");

  // A stalled point holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled point changed");

  // The input is ready whenever no point is waiting at the output.
  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready while output is empty");

endmodule

bind bresenham_line_generator_core brlg_checker #(.COORD_BITS(COORD_BITS)) u_brlg_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_bresenham_line_generator_core.sv =====
// Testbench for the Bresenham line generator: random stream traffic checked against a line predictor.
module tb_bresenham_line_generator_core;
  import brlg_pkg::*;

  localparam int CW    = COORD_BITS_DEF;
  localparam int IN_W  = ((4 * CW + 7) / 8) * 8;
  localparam int OUT_W = ((2 * CW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_ITEMS = 1700;
  localparam int CALM_TAIL = 150;

  typedef struct packed {
    logic              kind;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] xe;
    logic signed [CW-1:0] ye;
  } line_item_t;

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 last;
  } point_t;

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_tvalid = 1'b0;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic            in_tuser = 1'b0;
  logic            out_tvalid;
  logic            out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic            out_tlast;

  line_item_t pending_q[$];
  point_t     point_q[$];
  line_item_t cur_item;
  logic       took = 1'b0;
  int         send_gap = 0;
  int         recv_stall = 0;
  int         mismatches = 0;
  int         cycles = 0;
  int         counted = 0;

  logic signed [CW-1:0] cur_x = '0, cur_y = '0, goal_x = '0, goal_y = '0;
  int   span_x = 0, neg_span_y = 0, error_term = 0;
  logic step_x_neg = 1'b0, step_y_neg = 1'b0, line_active = 1'b0;

  bresenham_line_generator_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  function automatic int abs_int(input int v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic push_point();
    point_t p;
    p.px = cur_x;
    p.py = cur_y;
    p.last = (cur_x == goal_x) && (cur_y == goal_y);
    if (p.last) begin
      line_active = 1'b0;
    end
    point_q = {point_q, p};
  endtask

  // Steps the line state for one accepted item and queues the point, if it emits one.
  task automatic advance_line(input line_item_t it);
    int dxv;
    int dyv;
    int e2;
    if (it.kind == KIND_START) begin
      dxv = int'(it.xe) - int'(it.xs);
      dyv = int'(it.ye) - int'(it.ys);
      span_x = abs_int(dxv);
      neg_span_y = -abs_int(dyv);
      step_x_neg = !(it.xs < it.xe);
      step_y_neg = !(it.ys < it.ye);
      error_term = span_x + neg_span_y;
      cur_x = it.xs;
      cur_y = it.ys;
      goal_x = it.xe;
      goal_y = it.ye;
      line_active = 1'b1;
      push_point();
    end else if (line_active) begin
      e2 = 2 * error_term;
      if (e2 >= neg_span_y) begin
        error_term += neg_span_y;
        cur_x = step_x_neg ? cur_x - CW'(1) : cur_x + CW'(1);
      end
      if (e2 <= span_x) begin
        error_term += span_x;
        cur_y = step_y_neg ? cur_y - CW'(1) : cur_y + CW'(1);
      end
      push_point();
    end
  endtask

  task automatic add_tick();
    line_item_t it;
    it = '0;
    it.kind = KIND_TICK;
    it.xs = CW'($urandom);
    it.ys = CW'($urandom);
    it.xe = CW'($urandom);
    it.ye = CW'($urandom);
    pending_q = {pending_q, it};
  endtask

  // Queues a start item and a number of ticks; ticks past the end point are ignored by the block.
  task automatic add_line(input int xs, input int ys, input int xe, input int ye, input int nticks);
    line_item_t it;
    int len;
    it.kind = KIND_START;
    it.xs = CW'(xs);
    it.ys = CW'(ys);
    it.xe = CW'(xe);
    it.ye = CW'(ye);
    pending_q = {pending_q, it};
    len = abs_int(xe - xs);
    if (abs_int(ye - ys) > len) begin
      len = abs_int(ye - ys);
    end
    counted += 1 + ((nticks < len) ? nticks : len);
    for (int i = 0; i < nticks; i++) begin
      add_tick();
    end
  endtask

  function automatic int offset_coord(input int base, input int d);
    int v;
    v = base + d;
    if (v > 2047 || v < -2048) begin
      v = base - d;
    end
    return v;
  endfunction

  always @(posedge clk) begin
    took <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      advance_line(cur_item);
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || took)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 99) < 8) begin
        send_gap <= $urandom_range(1, 12) - 1;
        in_tvalid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_item = pending_q.pop_front();
        in_tdata <= {cur_item.ye, cur_item.xe, cur_item.ys, cur_item.xs};
        in_tuser <= cur_item.kind;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      out_tready <= 1'b0;
    end else if (pending_q.size() > CALM_TAIL && $urandom_range(0, 99) < 7) begin
      recv_stall <= $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (point_q.size() == 0) begin
        report_mismatch($sformatf("unexpected point px=%0d py=%0d last=%0b",
                                  $signed(out_tdata[CW-1:0]), $signed(out_tdata[2*CW-1:CW]),
                                  out_tlast));
      end else begin
        want = point_q.pop_front();
        if (out_tdata[CW-1:0] !== want.px) begin
          report_mismatch($sformatf("px got %0d want %0d",
                                    $signed(out_tdata[CW-1:0]), want.px));
        end
        if (out_tdata[2*CW-1:CW] !== want.py) begin
          report_mismatch($sformatf("py got %0d want %0d",
                                    $signed(out_tdata[2*CW-1:CW]), want.py));
        end
        if (out_tlast !== want.last) begin
          report_mismatch($sformatf("last got %0b want %0b at (%0d,%0d)",
                                    out_tlast, want.last, want.px, want.py));
        end
      end
    end
  end

  initial begin
    int sel;
    int xs;
    int ys;
    int xe;
    int ye;
    int reach;
    int len;
    int nticks;
    int r;

    add_tick();
    add_line(0, 0, 0, 0, 1);
    add_line(-2048, -2048, -2048, -2048, 0);
    add_line(2047, 2047, 2047, 2047, 0);
    add_line(-2048, 2047, 2047, -2048, 3);
    add_line(2047, -2048, 2044, -2046, 4);
    add_line(-5, 2, -4, 6, 4);
    add_line(10, -10, 14, -9, 4);
    add_line(1, 1, -1, -1, 2);

    while (counted < TARGET_ITEMS) begin
      sel = $urandom_range(0, 99);
      xs = $signed(CW'($urandom));
      ys = $signed(CW'($urandom));
      if (sel < 8) begin
        xe = $signed(CW'($urandom));
        ye = $signed(CW'($urandom));
        add_line(xs, ys, xe, ye, $urandom_range(0, 6));
      end else if (sel < 11) begin
        add_tick();
      end else if (sel < 14) begin
        add_line(xs, ys, xs, ys, $urandom_range(0, 2));
      end else begin
        reach = (sel < 84) ? 15 : 60;
        xe = offset_coord(xs, $urandom_range(0, 2 * reach) - reach);
        ye = offset_coord(ys, $urandom_range(0, 2 * reach) - reach);
        len = abs_int(xe - xs);
        if (abs_int(ye - ys) > len) begin
          len = abs_int(ye - ys);
        end
        r = $urandom_range(0, 99);
        if (r < 70 || len == 0) begin
          nticks = len;
        end else if (r < 85) begin
          nticks = len + $urandom_range(1, 3);
        end else begin
          nticks = $urandom_range(0, len - 1);
        end
        add_line(xs, ys, xe, ye, nticks);
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() > 0 || in_tvalid) begin
      @(posedge clk);
    end
    while (point_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
